/* rtl/msd_unwrap_accumulator_defines.svh */
// Assertion macros used by the checker of the MSD accumulator.
`ifndef MSD_UNWRAP_ACCUMULATOR_DEFINES_SVH
`define MSD_UNWRAP_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSDUA_ASSERT_IMPL(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MSDUA_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/msdua_pkg.sv */
package msdua_pkg;

	localparam int LAG_W  = 7;
	localparam int PIDX_W = 8;
	localparam int POS_W  = 32;
	localparam int DIFF_W = POS_W + 1;
	localparam int ACC_W  = 64;
	localparam int TIME_W = 32;
	localparam int CNT_W  = 32;
	localparam int BOX_W  = 31;

	localparam logic [BOX_W-1:0] BOX_RESET = 31'd16777216;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	// index 0 = x, 1 = y, 2 = z; two's complement Q16.16
	typedef logic [2:0][POS_W-1:0] vec_t;

	typedef struct packed {
		vec_t prev;
		vec_t unw;
	} pent_t;

	typedef struct packed {
		logic [ACC_W-1:0] tot;
		logic [ACC_W-1:0] stp;
		logic [ACC_W-1:0] tim;
	} lent_t;

	typedef struct packed {
		logic              vld;
		logic              rd;
		logic              smp;
		logic              org;
		logic              p0;
		logic              rng;
		logic [LAG_W-1:0]  lag;
		logic [PIDX_W-1:0] pidx;
	} ctl_t;

	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
		input logic [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
	endfunction

	// magnitude of a signed value known to fit in POS_W unsigned bits
	function automatic logic [POS_W-1:0] mag(input logic [DIFF_W-1:0] v);
		logic [DIFF_W-1:0] n;
		n = v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
		return n[POS_W-1:0];
	endfunction

endpackage

/* rtl/msdua_pmem.sv */
module msdua_pmem
	import msdua_pkg::*;
#(
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output pent_t         rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  pent_t         wr_data
);

	pent_t mem [DEPTH];
	pent_t rd_q;

	// write-through: a read of the entry written at the same edge returns the new word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

/* rtl/msdua_lmem.sv */
module msdua_lmem
	import msdua_pkg::*;
#(
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output lent_t         rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  lent_t         wr_data
);

	lent_t            mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	lent_t            rd_q;
	logic             rdv_q;
	logic             hit;

	assign hit = wr_en && (wr_addr == rd_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rdv_q <= hit || vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			if (hit) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	// never-written sums read as zero
	assign rd_data = rdv_q ? rd_q : '0;

endmodule

/* rtl/msdua_sqsum.sv */
module msdua_sqsum
	import msdua_pkg::*;
(
	input  logic                        clk,
	input  logic                        en,
	input  logic [2:0][POS_W-1:0]       fmag_s4,
	input  vec_t                        un_s4,
	output logic [ACC_W-1:0]            ssum_s7,
	output logic [ACC_W-1:0]            tsum_s7
);

	logic [2:0][ACC_W-1:0] sq_s5;
	logic [2:0][POS_W-1:0] umag_s5;
	logic [ACC_W-1:0]      ssum_s6;
	logic [2:0][ACC_W-1:0] tsq_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s5[i]   <= fmag_s4[i] * fmag_s4[i];
				umag_s5[i] <= mag({un_s4[i][POS_W-1], un_s4[i]});
				tsq_s6[i]  <= umag_s5[i] * umag_s5[i];
			end
			ssum_s6 <= sat_add(sat_add(sq_s5[0], sq_s5[1]), sq_s5[2]);
			ssum_s7 <= ssum_s6;
			tsum_s7 <= sat_add(sat_add(tsq_s6[0], tsq_s6[1]), tsq_s6[2]);
		end
	end

endmodule

/* rtl/msd_unwrap_accumulator.sv */
// MSD accumulator for periodic trajectories, Q16.16. Takes one transaction per clock: a
// sample or a read. An accepted read travels through stage 1 and six more pipeline stages
// before its result is loaded into the output register, where it then appears. Particle
// positions and unwrapped offsets live in one synchronous RAM (read on acceptance, written
// back in stage 3, with write-through and forwarding from stages 2 and 3, so the same
// particle may come back to back); the per-lag sums live in a second RAM read in stage 6
// and updated in stage 7, so consecutive samples at one lag add without a gap. The input
// stalls only while a read result sits in stage 7 and the output register still holds a
// result that is not taken. Per-lag sums come up zero from per-entry valid bits, so there
// is no clearing pass after reset. The user must write box_length only while the block is
// idle; the block itself does not enforce this. cfg_ready is always high.
module msd_unwrap_accumulator
	import msdua_pkg::*;
#(
	parameter int NUM_PARTICLES = 256,
	parameter int BLOCK_LAGS    = 128
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [BOX_W-1:0]    box_length,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic [0:0]          opcode,
	input  logic [LAG_W-1:0]    lag,
	input  logic [PIDX_W-1:0]   particle_index,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic [TIME_W-1:0]   frame_time,

	output logic                out_valid,
	input  logic                out_stall,
	output logic [LAG_W-1:0]    lag_out,
	output logic [ACC_W-1:0]    total_sq_sum,
	output logic [ACC_W-1:0]    step_sq_sum,
	output logic [ACC_W-1:0]    elapsed_sum,
	output logic [CNT_W-1:0]    blocks_seen
);

	localparam int PW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
	localparam int LW = (BLOCK_LAGS > 1) ? $clog2(BLOCK_LAGS) : 1;
	localparam int SW = POS_W + 2;

	typedef logic [2:0][DIFF_W-1:0] dvec_t;

	typedef struct packed {
		logic [TIME_W-1:0] elapsed;
		logic [CNT_W-1:0]  blocks;
	} aux_t;

	logic              adv;
	logic              acc_in;
	logic              lag_ok;
	logic              pidx_ok;
	ctl_t              ctl_in;
	logic [TIME_W-1:0] elapsed_in;

	logic [BOX_W-1:0]  box_q;
	logic [TIME_W-1:0] origin_q;
	logic [CNT_W-1:0]  cnt_q;

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	aux_t aux_s1, aux_s2, aux_s3, aux_s4, aux_s5, aux_s6, aux_s7;
	vec_t pos_s1, pos_s2, pos_s3;

	pent_t prd;
	pent_t pwr;
	logic  wr_p;
	vec_t  prev_f;
	dvec_t d_s1, d_s2, f_s2, f_s3;
	vec_t  unw_s2, unw_s3;
	vec_t  un_new;
	logic [2:0][POS_W-1:0] fmag_s3, fmag_s4;
	vec_t  un_s4;

	logic [ACC_W-1:0] ssum_s7, tsum_s7;
	lent_t lrd;
	lent_t lwr;
	logic  wr_l;
	logic  out_ld;

	logic              out_valid_q;
	logic [LAG_W-1:0]  lag_out_q;
	logic [ACC_W-1:0]  tot_q, stp_q, tim_q;
	logic [CNT_W-1:0]  blocks_q;

	// ---- acceptance and decode
	assign adv      = !(ctl_s7.vld && ctl_s7.rd && out_valid_q && out_stall);
	assign in_stall = !adv;
	assign acc_in   = in_valid && adv;
	assign cfg_ready = 1'b1;

	assign lag_ok     = 32'(lag) < 32'(BLOCK_LAGS);
	assign pidx_ok    = 32'(particle_index) < 32'(NUM_PARTICLES);
	assign elapsed_in = frame_time - origin_q;

	always_comb begin
		ctl_in.vld  = in_valid;
		ctl_in.rd   = (opcode == OP_READ);
		ctl_in.smp  = (opcode == OP_SAMPLE) && lag_ok && pidx_ok && (lag != '0);
		ctl_in.org  = (opcode == OP_SAMPLE) && lag_ok && pidx_ok && (lag == '0);
		ctl_in.p0   = (particle_index == '0);
		ctl_in.rng  = lag_ok;
		ctl_in.lag  = lag;
		ctl_in.pidx = particle_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q    <= BOX_RESET;
			origin_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (cfg_valid) begin
				box_q <= box_length;
			end
			if (acc_in && ctl_in.org) begin
				origin_q <= frame_time;
				if (ctl_in.p0 && (cnt_q != {CNT_W{1'b1}})) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// ---- control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	// ---- particle store
	assign wr_p     = adv && ctl_s3.vld && (ctl_s3.smp || ctl_s3.org);
	assign pwr.prev = pos_s3;
	assign pwr.unw  = un_new;

	msdua_pmem #(
		.DEPTH (NUM_PARTICLES)
	) u_pmem (
		.clk     (clk),
		.rd_en   (adv),
		.rd_addr (PW'(particle_index)),
		.rd_data (prd),
		.wr_en   (wr_p),
		.wr_addr (PW'(ctl_s3.pidx)),
		.wr_data (pwr)
	);

	// s1: last position, forwarded from samples of the same particle still in flight
	always_comb begin
		prev_f = prd.prev;
		if (ctl_s3.vld && (ctl_s3.smp || ctl_s3.org) && (ctl_s3.pidx == ctl_s1.pidx)) begin
			prev_f = pos_s3;
		end
		if (ctl_s2.vld && (ctl_s2.smp || ctl_s2.org) && (ctl_s2.pidx == ctl_s1.pidx)) begin
			prev_f = pos_s2;
		end
		for (int i = 0; i < 3; i++) begin
			d_s1[i] = {pos_s1[i][POS_W-1], pos_s1[i]} - {prev_f[i][POS_W-1], prev_f[i]};
		end
	end

	// s2: minimum image, exactly half a box stays
	always_comb begin
		logic [DIFF_W:0] d34;
		logic [DIFF_W:0] two_d;
		logic [DIFF_W:0] box34;
		logic [DIFF_W:0] f34;
		box34 = {{(DIFF_W+1-BOX_W){1'b0}}, box_q};
		for (int i = 0; i < 3; i++) begin
			d34   = {d_s2[i][DIFF_W-1], d_s2[i]};
			two_d = {d_s2[i], 1'b0};
			if ($signed(two_d) > $signed(box34)) begin
				f34 = d34 - box34;
			end else if ($signed(two_d) < -$signed(box34)) begin
				f34 = d34 + box34;
			end else begin
				f34 = d34;
			end
			f_s2[i] = f34[DIFF_W-1:0];
		end
	end

	// s3: saturating unwrap (cleared on an origin sample), write-back
	always_comb begin
		logic [SW-1:0] sum;
		for (int i = 0; i < 3; i++) begin
			sum = {{2{unw_s3[i][POS_W-1]}}, unw_s3[i]} + {f_s3[i][DIFF_W-1], f_s3[i]};
			if ((sum[SW-1:POS_W-1] != '0) && (sum[SW-1:POS_W-1] != '1)) begin
				un_new[i] = sum[SW-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
			end else begin
				un_new[i] = sum[POS_W-1:0];
			end
			if (ctl_s3.org) begin
				un_new[i] = '0;
			end
			fmag_s3[i] = mag(f_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1 <= {pos_z, pos_y, pos_x};
			pos_s2 <= pos_s1;
			pos_s3 <= pos_s2;
			d_s2   <= d_s1;
			f_s3   <= f_s2;
			unw_s2 <= (wr_p && (ctl_s3.pidx == ctl_s1.pidx)) ? un_new : prd.unw;
			unw_s3 <= (wr_p && (ctl_s3.pidx == ctl_s2.pidx)) ? un_new : unw_s2;
			fmag_s4 <= fmag_s3;
			un_s4   <= un_new;
			aux_s1 <= {elapsed_in, cnt_q};
			aux_s2 <= aux_s1;
			aux_s3 <= aux_s2;
			aux_s4 <= aux_s3;
			aux_s5 <= aux_s4;
			aux_s6 <= aux_s5;
			aux_s7 <= aux_s6;
		end
	end

	// s4..s7: squares and their sums
	msdua_sqsum u_sqsum (
		.clk     (clk),
		.en      (adv),
		.fmag_s4 (fmag_s4),
		.un_s4   (un_s4),
		.ssum_s7 (ssum_s7),
		.tsum_s7 (tsum_s7)
	);

	// ---- per-lag sums: read in s6, update in s7
	assign wr_l    = adv && ctl_s7.vld && ctl_s7.smp;
	assign lwr.tot = sat_add(lrd.tot, tsum_s7);
	assign lwr.stp = sat_add(lrd.stp, ssum_s7);
	assign lwr.tim = ctl_s7.p0 ?
		sat_add(lrd.tim, {{(ACC_W-TIME_W){1'b0}}, aux_s7.elapsed}) : lrd.tim;

	msdua_lmem #(
		.DEPTH (BLOCK_LAGS)
	) u_lmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (adv),
		.rd_addr (LW'(ctl_s6.lag)),
		.rd_data (lrd),
		.wr_en   (wr_l),
		.wr_addr (LW'(ctl_s7.lag)),
		.wr_data (lwr)
	);

	// ---- result register
	assign out_ld = adv && ctl_s7.vld && ctl_s7.rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			lag_out_q <= ctl_s7.lag;
			tot_q     <= ctl_s7.rng ? lrd.tot : '0;
			stp_q     <= ctl_s7.rng ? lrd.stp : '0;
			tim_q     <= ctl_s7.rng ? lrd.tim : '0;
			blocks_q  <= aux_s7.blocks;
		end
	end

	assign out_valid    = out_valid_q;
	assign lag_out      = lag_out_q;
	assign total_sq_sum = tot_q;
	assign step_sq_sum  = stp_q;
	assign elapsed_sum  = tim_q;
	assign blocks_seen  = blocks_q;

endmodule

/* rtl/msdua_chk.sv */
`include "msd_unwrap_accumulator_defines.svh"

module msdua_chk
	import msdua_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [0:0]         opcode,
	input logic               out_valid,
	input logic               out_stall,
	input logic [LAG_W-1:0]   lag_out,
	input logic [ACC_W-1:0]   total_sq_sum,
	input logic [ACC_W-1:0]   step_sq_sum,
	input logic [ACC_W-1:0]   elapsed_sum,
	input logic [CNT_W-1:0]   blocks_seen
);

	logic [3:0]       pend_q;
	logic [CNT_W-1:0] last_q;
	logic             rd_acc;
	logic             out_acc;

	assign rd_acc  = in_valid && !in_stall && (opcode == OP_READ);
	assign out_acc = out_valid && !out_stall;

	// reads accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			last_q <= '0;
		end else begin
			pend_q <= pend_q + 4'(rd_acc) - 4'(out_acc);
			if (out_acc) begin
				last_q <= blocks_seen;
			end
		end
	end

	`MSDUA_ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without a held result")
	`MSDUA_ASSERT_IMPL(a_no_spurious, clk, arst_n, out_valid, pend_q != 4'd0, "result without an outstanding read")
	`MSDUA_ASSERT_IMPL(a_blocks_mono, clk, arst_n, out_acc, blocks_seen >= last_q, "block count went backwards")
	`MSDUA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(lag_out) && $stable(total_sq_sum) && $stable(step_sq_sum) && $stable(elapsed_sum) && $stable(blocks_seen), "stalled result changed")

endmodule

bind msd_unwrap_accumulator msdua_chk u_msdua_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.opcode       (opcode),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.lag_out      (lag_out),
	.total_sq_sum (total_sq_sum),
	.step_sq_sum  (step_sq_sum),
	.elapsed_sum  (elapsed_sum),
	.blocks_seen  (blocks_seen)
);

/* sim/msd_unwrap_accumulator_chk.sv */
`timescale 1ns / 1ps

module msd_unwrap_accumulator_chk
	import msdua_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [BOX_W-1:0]        box_length,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic [0:0]              opcode,
	input  logic [LAG_W-1:0]        lag,
	input  logic [PIDX_W-1:0]       particle_index,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic [TIME_W-1:0]       frame_time,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic [LAG_W-1:0]        lag_out,
	input  logic [ACC_W-1:0]        total_sq_sum,
	input  logic [ACC_W-1:0]        step_sq_sum,
	input  logic [ACC_W-1:0]        elapsed_sum,
	input  logic [CNT_W-1:0]        blocks_seen,
	output int                      fail_count,
	output int                      results_due
);

	localparam int PARTICLES = 256;
	localparam int LAGS      = 128;

	typedef struct {
		logic [LAG_W-1:0] lag;
		logic [ACC_W-1:0] total;
		logic [ACC_W-1:0] step;
		logic [ACC_W-1:0] elapsed;
		logic [CNT_W-1:0] blocks;
	} lag_sums_t;

	logic [BOX_W-1:0]  box_reg;
	int                last_pos [PARTICLES][3];
	int                unwrapped [PARTICLES][3];
	logic [ACC_W-1:0]  lag_total [LAGS];
	logic [ACC_W-1:0]  lag_step [LAGS];
	logic [ACC_W-1:0]  lag_elapsed [LAGS];
	logic [TIME_W-1:0] origin_tick;
	logic [CNT_W-1:0]  block_count;
	lag_sums_t         sums_due [$];

	function automatic logic [ACC_W-1:0] add_sat(input logic [ACC_W-1:0] a,
		input logic [ACC_W-1:0] b);
		logic [ACC_W-1:0] s;
		s = a + b;
		return (s < a) ? '1 : s;
	endfunction

	function automatic longint min_image(input longint d);
		longint b;
		b = box_reg;
		if (2 * d > b)
			d = d - b;
		else if (2 * d < -b)
			d = d + b;
		return d;
	endfunction

	function automatic logic [ACC_W-1:0] sq_mag(input longint v);
		logic [ACC_W-1:0] m;
		m = (v < 0) ? -v : v;
		return m * m;
	endfunction

	function automatic int clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return int'(v);
	endfunction

	always @(posedge clk) begin
		lag_sums_t        want;
		int               now_pos [3];
		longint           d;
		logic [ACC_W-1:0] jump;
		logic [ACC_W-1:0] reach;
		logic [TIME_W-1:0] dt;
		int               p;
		int               k;
		if (!arst_n) begin
			box_reg = BOX_RESET;
			for (k = 0; k < LAGS; k++) begin
				lag_total[k] = '0;
				lag_step[k] = '0;
				lag_elapsed[k] = '0;
			end
			origin_tick = '0;
			block_count = '0;
			sums_due.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				box_reg = box_length;

			if (out_valid && !out_stall) begin
				if (sums_due.size() == 0) begin
					$error("result transaction with no read outstanding: lag_out %0d", lag_out);
					fail_count++;
				end else begin
					want = sums_due.pop_front();
					if (lag_out !== want.lag) begin
						$error("lag_out: expected %0d, actual %0d", want.lag, lag_out);
						fail_count++;
					end
					if (total_sq_sum !== want.total) begin
						$error("total_sq_sum (lag %0d): expected %0h, actual %0h",
							want.lag, want.total, total_sq_sum);
						fail_count++;
					end
					if (step_sq_sum !== want.step) begin
						$error("step_sq_sum (lag %0d): expected %0h, actual %0h",
							want.lag, want.step, step_sq_sum);
						fail_count++;
					end
					if (elapsed_sum !== want.elapsed) begin
						$error("elapsed_sum (lag %0d): expected %0h, actual %0h",
							want.lag, want.elapsed, elapsed_sum);
						fail_count++;
					end
					if (blocks_seen !== want.blocks) begin
						$error("blocks_seen (lag %0d): expected %0d, actual %0d",
							want.lag, want.blocks, blocks_seen);
						fail_count++;
					end
				end
			end

			if (in_valid && !in_stall) begin
				p = particle_index;
				if (opcode == OP_READ) begin
					want.lag = lag;
					want.total = lag_total[lag];
					want.step = lag_step[lag];
					want.elapsed = lag_elapsed[lag];
					want.blocks = block_count;
					sums_due.push_back(want);
				end else if (lag == 0) begin
					last_pos[p] = '{pos_x, pos_y, pos_z};
					unwrapped[p] = '{0, 0, 0};
					origin_tick = frame_time;
					if (p == 0 && block_count != '1)
						block_count++;
				end else begin
					now_pos = '{pos_x, pos_y, pos_z};
					jump = '0;
					reach = '0;
					for (k = 0; k < 3; k++) begin
						d = min_image(longint'(now_pos[k]) - longint'(last_pos[p][k]));
						jump = add_sat(jump, sq_mag(d));
						unwrapped[p][k] = clamp32(longint'(unwrapped[p][k]) + d);
						reach = add_sat(reach, sq_mag(unwrapped[p][k]));
					end
					lag_step[lag] = add_sat(lag_step[lag], jump);
					lag_total[lag] = add_sat(lag_total[lag], reach);
					last_pos[p] = now_pos;
					if (p == 0) begin
						dt = frame_time - origin_tick;
						lag_elapsed[lag] = add_sat(lag_elapsed[lag], {32'b0, dt});
					end
				end
			end
		end
		results_due = sums_due.size();
	end

endmodule

/* sim/tb_msd_unwrap_accumulator.sv */
`timescale 1ns / 1ps

module tb_msd_unwrap_accumulator;
	import msdua_pkg::*;

	localparam int ITEM_TARGET = 1300;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN       = 12;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [BOX_W-1:0]        box_length = BOX_RESET;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [0:0]              opcode = OP_SAMPLE;
	logic [LAG_W-1:0]        lag = '0;
	logic [PIDX_W-1:0]       particle_index = '0;
	logic signed [POS_W-1:0] pos_x = '0;
	logic signed [POS_W-1:0] pos_y = '0;
	logic signed [POS_W-1:0] pos_z = '0;
	logic [TIME_W-1:0]       frame_time = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [LAG_W-1:0]        lag_out;
	logic [ACC_W-1:0]        total_sq_sum;
	logic [ACC_W-1:0]        step_sq_sum;
	logic [ACC_W-1:0]        elapsed_sum;
	logic [CNT_W-1:0]        blocks_seen;
	int                      fail_count;
	int                      results_due;

	int                      cycle_count = 0;
	int                      item_total = 0;
	int                      trail [256][3];
	logic [BOX_W-1:0]        box_now = BOX_RESET;
	bit                      quiet_in = 1'b0;
	bit                      quiet_out = 1'b0;

	msd_unwrap_accumulator DUT (.*);
	msd_unwrap_accumulator_chk CHK (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side: random stall before each transaction, with quiet stretches
	initial begin : result_sink
		int hold;
		@(negedge clk);
		forever begin
			hold = quiet_out ? 0 : $urandom_range(0, 12);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
			if ($urandom_range(0, 19) == 0)
				quiet_out = !quiet_out;
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic offer(input op_t op, input int at_lag, input int pid, input int x,
		input int y, input int z, input logic [TIME_W-1:0] t);
		int gap;
		gap = quiet_in ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode <= op;
		lag <= LAG_W'(at_lag);
		particle_index <= PIDX_W'(pid);
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		frame_time <= t;
		in_valid <= 1'b1;
		if (op == OP_SAMPLE)
			trail[pid] = '{x, y, z};
		item_total++;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic fetch_sums(input int at_lag);
		offer(OP_READ, at_lag, $urandom_range(0, 255), $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_box(input logic [BOX_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		box_length <= v;
		box_now = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		box_length <= BOX_W'($urandom);
		@(negedge clk);
	endtask

	// next coordinate: mostly near moves, some across half a box or beyond
	function automatic int drift(input int from);
		longint b;
		longint mag;
		b = box_now;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1, 2: mag = $urandom_range(b / 2, b);
			3: mag = b / 2;
			4: mag = $urandom_range(b, 2 * b);
			default: mag = $urandom_range(0, b / 2);
		endcase
		if ($urandom_range(0, 1))
			mag = -mag;
		return int'(longint'(from) + mag);
	endfunction

	task automatic run_block(input int members, input int span);
		int                crew [8];
		logic [TIME_W-1:0] tick;
		int                k;
		int                m;
		int                pid;
		tick = $urandom;
		crew[0] = ($urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 255);
		for (k = 1; k < members; k++)
			crew[k] = $urandom_range(0, 255);
		quiet_in = ($urandom_range(0, 3) == 0);
		for (k = 0; k < span; k++) begin
			for (m = 0; m < members; m++) begin
				pid = crew[m];
				if (k == 0)
					offer(OP_SAMPLE, 0, pid, $urandom, $urandom, $urandom, tick);
				else
					offer(OP_SAMPLE, k, pid, drift(trail[pid][0]), drift(trail[pid][1]),
						drift(trail[pid][2]), tick);
				if ($urandom_range(0, 7) == 0)
					fetch_sums(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) :
						$urandom_range(0, span - 1));
				// out-of-order sample at a stray lag
				if (k > 0 && $urandom_range(0, 29) == 0)
					offer(OP_SAMPLE, $urandom_range(1, 127), crew[$urandom_range(0, members - 1)],
						$urandom, $urandom, $urandom, $urandom);
			end
			tick += $urandom_range(1, 5000);
		end
	endtask

	initial begin : stimulus
		int phase;
		int blocks;
		int b;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// default box: exact half kept, beyond half folded, elapsed wraps
		fetch_sums(0);
		offer(OP_SAMPLE, 0, 0, 0, 0, 0, 32'h0000_0100);
		offer(OP_SAMPLE, 0, 255, 32'sh7FFFFFFF, 32'sh80000000, 0, 32'hFFFF_FFF0);
		offer(OP_SAMPLE, 1, 0, 8388608, -8388608, 8388609, 32'h0000_0010);
		offer(OP_SAMPLE, 1, 255, 32'sh80000000, 32'sh7FFFFFFF, -8388609, 32'h0000_0020);
		offer(OP_SAMPLE, 1, 0, 1, 2, 3, 32'h0000_0030);
		fetch_sums(1);
		fetch_sums(127);

		// zero box: no folding, offsets and sums saturate
		write_box('0);
		offer(OP_SAMPLE, 0, 128, 32'sh80000000, 32'sh80000000, 32'sh80000000, '0);
		offer(OP_SAMPLE, 2, 128, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'd9);
		offer(OP_SAMPLE, 3, 128, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'd9);
		offer(OP_SAMPLE, 3, 128, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'd9);
		offer(OP_SAMPLE, 127, 0, -1, -1, -1, 32'hFFFF_FFFF);
		offer(OP_SAMPLE, 127, 0, 32'sh80000000, 0, 32'sh7FFFFFFF, 32'hFFFF_FFFF);
		fetch_sums(2);
		fetch_sums(3);
		fetch_sums(127);

		write_box('1);
		offer(OP_SAMPLE, 0, 1, 32'sh80000000, 0, 32'sh7FFFFFFF, 32'd7);
		offer(OP_SAMPLE, 64, 1, 32'sh7FFFFFFF, -1073741824, 32'sh80000000, 32'd8);
		fetch_sums(64);

		write_box(31'd1);
		offer(OP_SAMPLE, 0, 2, 0, 0, 0, 32'd1);
		offer(OP_SAMPLE, 5, 2, 1, -1, 0, 32'd2);
		fetch_sums(5);

		phase = 0;
		while (item_total < ITEM_TARGET) begin
			case (phase % 7)
				0: write_box(31'd1);
				1: write_box('1);
				2: write_box(BOX_RESET);
				3: write_box('0);
				4: write_box(BOX_W'($urandom_range(1, 4096)));
				5: write_box(BOX_W'($urandom));
				default: write_box(31'd1 << $urandom_range(1, 30));
			endcase
			blocks = $urandom_range(3, 6);
			for (b = 0; b < blocks && item_total < ITEM_TARGET; b++) begin
				if (phase == 2 && b == 0)
					run_block(1, 128);
				else if ($urandom_range(0, 4) == 0)
					run_block($urandom_range(1, 8), $urandom_range(9, 24));
				else
					run_block($urandom_range(1, 4), $urandom_range(2, 8));
				if ($urandom_range(0, 5) == 0)
					settle();
			end
			phase++;
		end

		settle();
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
